// ===== hdl/rti_pkg.sv =====
// shared widths, codes and payload types of the ray-triangle intersection core
package rti_pkg;

	localparam int COORD_W = 32;
	localparam int EDGE_W = COORD_W + 1;
	localparam int DIR_W = 18;
	localparam int EPS_W = 16;
	localparam int CROSS_P_W = 52;
	localparam int CROSS_Q_W = 67;
	localparam int DOT_W = 87;
	localparam int NT_W = 102;
	localparam int P_LO_W = 26;
	localparam int Q_LO_W = 34;
	localparam int BARY_FRAC = 16;
	localparam int BARY_W = BARY_FRAC + 1;
	localparam int DIST_FRAC = 16;
	localparam int DIST_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] MISS_NONE = 2'd0;
	localparam logic [1:0] MISS_PARALLEL = 2'd1;
	localparam logic [1:0] MISS_U = 2'd2;
	localparam logic [1:0] MISS_V = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DET_EPS = 3'd6;

	typedef struct packed {
		logic signed [COORD_W-1:0] org_x;
		logic signed [COORD_W-1:0] org_y;
		logic signed [COORD_W-1:0] org_z;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
		logic [EPS_W-1:0] det_eps;
	} rti_ray_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] v0_x;
		logic signed [COORD_W-1:0] v0_y;
		logic signed [COORD_W-1:0] v0_z;
		logic signed [COORD_W-1:0] v1_x;
		logic signed [COORD_W-1:0] v1_y;
		logic signed [COORD_W-1:0] v1_z;
		logic signed [COORD_W-1:0] v2_x;
		logic signed [COORD_W-1:0] v2_y;
		logic signed [COORD_W-1:0] v2_z;
	} rti_facet_t;

	// classified triangle waiting for the divider
	typedef struct packed {
		logic hit;
		logic [1:0] reason;
		logic [DOT_W-1:0] det;
		logic [DOT_W-1:0] nu;
		logic [DOT_W-1:0] nv;
		logic [NT_W-1:0] mag;
		logic neg;
	} rti_item_t;

endpackage

// ===== hdl/rti_front.sv =====
// front pipeline: edges, cross and dot products, sign fix and miss classification
module rti_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input rti_pkg::rti_facet_t facet,
	input rti_pkg::rti_ray_t ray,
	output logic item_valid,
	output rti_pkg::rti_item_t item
);
	import rti_pkg::*;

	localparam int PH_W = CROSS_P_W - P_LO_W;
	localparam int QH_W = CROSS_Q_W - Q_LO_W;

	logic signed [COORD_W-1:0] va [3];
	logic signed [COORD_W-1:0] vb [3];
	logic signed [COORD_W-1:0] vc [3];
	logic signed [COORD_W-1:0] org [3];
	logic signed [DIR_W-1:0] dir [3];

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;

	logic signed [EDGE_W-1:0] e1_s1 [3];
	logic signed [EDGE_W-1:0] e2_s1 [3];
	logic signed [EDGE_W-1:0] s_s1 [3];
	logic signed [DIR_W-1:0] d_s1 [3];

	logic signed [EDGE_W-1:0] e1_s2 [3];
	logic signed [EDGE_W-1:0] e2_s2 [3];
	logic signed [EDGE_W-1:0] s_s2 [3];
	logic signed [DIR_W-1:0] d_s2 [3];
	logic signed [DIR_W+EDGE_W-1:0] pa_s2 [3];
	logic signed [DIR_W+EDGE_W-1:0] pb_s2 [3];
	logic signed [2*EDGE_W-1:0] qa_s2 [3];
	logic signed [2*EDGE_W-1:0] qb_s2 [3];

	logic signed [EDGE_W-1:0] e1_s3 [3];
	logic signed [EDGE_W-1:0] e2_s3 [3];
	logic signed [EDGE_W-1:0] s_s3 [3];
	logic signed [DIR_W-1:0] d_s3 [3];
	logic signed [CROSS_P_W-1:0] p_s3 [3];
	logic signed [CROSS_Q_W-1:0] q_s3 [3];

	logic signed [EDGE_W+PH_W-1:0] det_hi_s4 [3];
	logic signed [EDGE_W+P_LO_W:0] det_lo_s4 [3];
	logic signed [EDGE_W+PH_W-1:0] nu_hi_s4 [3];
	logic signed [EDGE_W+P_LO_W:0] nu_lo_s4 [3];
	logic signed [DIR_W+QH_W-1:0] nv_hi_s4 [3];
	logic signed [DIR_W+Q_LO_W:0] nv_lo_s4 [3];
	logic signed [EDGE_W+QH_W-1:0] nt_hi_s4 [3];
	logic signed [EDGE_W+Q_LO_W:0] nt_lo_s4 [3];

	logic signed [DOT_W-1:0] det_t_s5 [3];
	logic signed [DOT_W-1:0] nu_t_s5 [3];
	logic signed [DOT_W-1:0] nv_t_s5 [3];
	logic signed [NT_W-1:0] nt_t_s5 [3];

	logic signed [DOT_W-1:0] det_s6, nu_s6, nv_s6;
	logic signed [NT_W-1:0] nt_s6;
	logic signed [DOT_W-1:0] det_s7, nu_s7, nv_s7;
	logic signed [NT_W-1:0] nt_s7;

	logic signed [DOT_W:0] uv_sum;
	logic det_small, u_bad, v_bad, nt_neg;
	logic [1:0] reason;

	assign va[0] = facet.v0_x;
	assign va[1] = facet.v0_y;
	assign va[2] = facet.v0_z;
	assign vb[0] = facet.v1_x;
	assign vb[1] = facet.v1_y;
	assign vb[2] = facet.v1_z;
	assign vc[0] = facet.v2_x;
	assign vc[1] = facet.v2_y;
	assign vc[2] = facet.v2_z;
	assign org[0] = ray.org_x;
	assign org[1] = ray.org_y;
	assign org[2] = ray.org_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			// edges and origin offset
			e1_s1[k] <= EDGE_W'(vb[k]) - EDGE_W'(va[k]);
			e2_s1[k] <= EDGE_W'(vc[k]) - EDGE_W'(va[k]);
			s_s1[k] <= EDGE_W'(org[k]) - EDGE_W'(va[k]);
			d_s1[k] <= dir[k];

			e1_s2[k] <= e1_s1[k];
			e2_s2[k] <= e2_s1[k];
			s_s2[k] <= s_s1[k];
			d_s2[k] <= d_s1[k];

			e1_s3[k] <= e1_s2[k];
			e2_s3[k] <= e2_s2[k];
			s_s3[k] <= s_s2[k];
			d_s3[k] <= d_s2[k];
			p_s3[k] <= CROSS_P_W'(pa_s2[k]) - CROSS_P_W'(pb_s2[k]);
			q_s3[k] <= CROSS_Q_W'(qa_s2[k]) - CROSS_Q_W'(qb_s2[k]);

			// dot products split on the wide operand
			det_hi_s4[k] <= e1_s3[k] * $signed(p_s3[k][CROSS_P_W-1:P_LO_W]);
			det_lo_s4[k] <= e1_s3[k] * $signed({1'b0, p_s3[k][P_LO_W-1:0]});
			nu_hi_s4[k] <= s_s3[k] * $signed(p_s3[k][CROSS_P_W-1:P_LO_W]);
			nu_lo_s4[k] <= s_s3[k] * $signed({1'b0, p_s3[k][P_LO_W-1:0]});
			nv_hi_s4[k] <= d_s3[k] * $signed(q_s3[k][CROSS_Q_W-1:Q_LO_W]);
			nv_lo_s4[k] <= d_s3[k] * $signed({1'b0, q_s3[k][Q_LO_W-1:0]});
			nt_hi_s4[k] <= e2_s3[k] * $signed(q_s3[k][CROSS_Q_W-1:Q_LO_W]);
			nt_lo_s4[k] <= e2_s3[k] * $signed({1'b0, q_s3[k][Q_LO_W-1:0]});

			det_t_s5[k] <= (DOT_W'(det_hi_s4[k]) <<< P_LO_W) + DOT_W'(det_lo_s4[k]);
			nu_t_s5[k] <= (DOT_W'(nu_hi_s4[k]) <<< P_LO_W) + DOT_W'(nu_lo_s4[k]);
			nv_t_s5[k] <= (DOT_W'(nv_hi_s4[k]) <<< Q_LO_W) + DOT_W'(nv_lo_s4[k]);
			nt_t_s5[k] <= (NT_W'(nt_hi_s4[k]) <<< Q_LO_W) + NT_W'(nt_lo_s4[k]);
		end

		// p = dir x e2, q = s x e1
		pa_s2[0] <= d_s1[1] * e2_s1[2];
		pb_s2[0] <= d_s1[2] * e2_s1[1];
		pa_s2[1] <= d_s1[2] * e2_s1[0];
		pb_s2[1] <= d_s1[0] * e2_s1[2];
		pa_s2[2] <= d_s1[0] * e2_s1[1];
		pb_s2[2] <= d_s1[1] * e2_s1[0];
		qa_s2[0] <= s_s1[1] * e1_s1[2];
		qb_s2[0] <= s_s1[2] * e1_s1[1];
		qa_s2[1] <= s_s1[2] * e1_s1[0];
		qb_s2[1] <= s_s1[0] * e1_s1[2];
		qa_s2[2] <= s_s1[0] * e1_s1[1];
		qb_s2[2] <= s_s1[1] * e1_s1[0];

		det_s6 <= det_t_s5[0] + det_t_s5[1] + det_t_s5[2];
		nu_s6 <= nu_t_s5[0] + nu_t_s5[1] + nu_t_s5[2];
		nv_s6 <= nv_t_s5[0] + nv_t_s5[1] + nv_t_s5[2];
		nt_s6 <= nt_t_s5[0] + nt_t_s5[1] + nt_t_s5[2];

		// make the determinant nonnegative
		if (det_s6[DOT_W-1]) begin
			det_s7 <= -det_s6;
			nu_s7 <= -nu_s6;
			nv_s7 <= -nv_s6;
			nt_s7 <= -nt_s6;
		end else begin
			det_s7 <= det_s6;
			nu_s7 <= nu_s6;
			nv_s7 <= nv_s6;
			nt_s7 <= nt_s6;
		end
	end

	always_comb begin
		det_small = (det_s7 == '0) || ($unsigned(det_s7) < DOT_W'(ray.det_eps));
		u_bad = nu_s7[DOT_W-1] || (nu_s7 > det_s7);
		uv_sum = (DOT_W+1)'(nu_s7) + (DOT_W+1)'(nv_s7);
		v_bad = nv_s7[DOT_W-1] || (uv_sum > (DOT_W+1)'(det_s7));
		nt_neg = nt_s7[NT_W-1];
		if (det_small) begin
			reason = MISS_PARALLEL;
		end else if (u_bad) begin
			reason = MISS_U;
		end else if (v_bad) begin
			reason = MISS_V;
		end else begin
			reason = MISS_NONE;
		end
	end

	always_ff @(posedge clk) begin
		item.hit <= (reason == MISS_NONE);
		item.reason <= reason;
		item.det <= det_s7;
		item.nu <= nu_s7;
		item.nv <= nv_s7;
		item.mag <= nt_neg ? $unsigned(-nt_s7) : $unsigned(nt_s7);
		item.neg <= nt_neg;
	end

	assign item_valid = valid_s8;

endmodule

// ===== hdl/rti_queue.sv =====
// queue of classified triangles between the front pipeline and the divider
module rti_queue #(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input rti_pkg::rti_item_t din,
	input logic pop,
	output logic head_valid,
	output rti_pkg::rti_item_t head
);
	import rti_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rti_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

endmodule

// ===== hdl/rti_back.sv =====
// back pipeline: restoring dividers for distance and barycentrics, output register
module rti_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input rti_pkg::rti_item_t head,
	output logic pop,
	output logic res_valid,
	input logic res_stall,
	output logic hit,
	output logic [1:0] miss_reason,
	output logic signed [rti_pkg::DIST_W-1:0] hit_distance,
	output logic [rti_pkg::BARY_W-1:0] bary_u,
	output logic [rti_pkg::BARY_W-1:0] bary_v
);
	import rti_pkg::*;

	localparam int RW = DOT_W + 1;
	localparam int NSTEP = DIST_W;
	localparam int MLO_STAGES = NSTEP - DIST_FRAC;
	localparam int OVF_W = DOT_W + DIST_FRAC;

	logic en;
	logic vld_q [NSTEP+1];
	logic hit_q [NSTEP+1];
	logic [1:0] reason_q [NSTEP+1];
	logic neg_q [NSTEP+1];
	logic ovf_q [NSTEP+1];
	logic [DOT_W-1:0] det_q [NSTEP];
	logic [RW-1:0] rt_q [NSTEP];
	logic [DIST_FRAC-1:0] mlo_q [MLO_STAGES];
	logic [RW-1:0] ru_q [BARY_W];
	logic [RW-1:0] rv_q [BARY_W];
	logic [DIST_W-1:0] qt_q [NSTEP+1];
	logic [BARY_W-1:0] qu_q [NSTEP+1];
	logic [BARY_W-1:0] qv_q [NSTEP+1];

	logic [DIST_W-1:0] qt_fin;
	logic pos_cap, neg_cap;
	logic [DIST_W-1:0] dist_sat;

	assign en = !(res_valid && res_stall);
	assign pop = en && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSTEP; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= head_valid;
			for (int k = 1; k <= NSTEP; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q[0] <= head.hit;
			reason_q[0] <= head.reason;
			neg_q[0] <= head.neg;
			// quotient of the distance would not fit in 32 bits
			ovf_q[0] <= OVF_W'(head.mag) >= {head.det, {DIST_FRAC{1'b0}}};
			det_q[0] <= head.det;
			rt_q[0] <= RW'(head.mag >> DIST_FRAC);
			mlo_q[0] <= head.mag[DIST_FRAC-1:0];
			ru_q[0] <= RW'(head.nu);
			rv_q[0] <= RW'(head.nv);
			qt_q[0] <= '0;
			qu_q[0] <= '0;
			qv_q[0] <= '0;
			for (int k = 1; k <= NSTEP; k++) begin
				hit_q[k] <= hit_q[k-1];
				reason_q[k] <= reason_q[k-1];
				neg_q[k] <= neg_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	for (genvar k = 1; k <= NSTEP; k++) begin : g_step
		localparam int NBIT = NSTEP - k;
		logic nb;
		logic [RW-1:0] tsh;
		logic tge;

		if (NBIT >= DIST_FRAC) begin : g_num
			assign nb = mlo_q[k-1][NBIT-DIST_FRAC];
		end else begin : g_frac
			assign nb = 1'b0;
		end

		assign tsh = {rt_q[k-1][RW-2:0], nb};
		assign tge = tsh >= RW'(det_q[k-1]);

		always_ff @(posedge clk) begin
			if (en) begin
				qt_q[k] <= {qt_q[k-1][DIST_W-2:0], tge};
			end
		end

		if (k < NSTEP) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					det_q[k] <= det_q[k-1];
					rt_q[k] <= tge ? tsh - RW'(det_q[k-1]) : tsh;
				end
			end
		end

		if (k < MLO_STAGES) begin : g_mlo
			always_ff @(posedge clk) begin
				if (en) begin
					mlo_q[k] <= mlo_q[k-1];
				end
			end
		end

		if (k <= BARY_W) begin : g_bary
			logic [RW-1:0] ush, vsh;
			logic uge, vge;
			// top quotient bit compares the unshifted numerator
			if (k == 1) begin : g_first
				assign ush = ru_q[k-1];
				assign vsh = rv_q[k-1];
			end else begin : g_next
				assign ush = {ru_q[k-1][RW-2:0], 1'b0};
				assign vsh = {rv_q[k-1][RW-2:0], 1'b0};
			end
			assign uge = ush >= RW'(det_q[k-1]);
			assign vge = vsh >= RW'(det_q[k-1]);

			always_ff @(posedge clk) begin
				if (en) begin
					qu_q[k] <= {qu_q[k-1][BARY_W-2:0], uge};
					qv_q[k] <= {qv_q[k-1][BARY_W-2:0], vge};
				end
			end

			if (k < BARY_W) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						ru_q[k] <= uge ? ush - RW'(det_q[k-1]) : ush;
						rv_q[k] <= vge ? vsh - RW'(det_q[k-1]) : vsh;
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					qu_q[k] <= qu_q[k-1];
					qv_q[k] <= qv_q[k-1];
				end
			end
		end
	end

	// saturate the distance to the signed 32-bit range
	always_comb begin
		qt_fin = qt_q[NSTEP];
		pos_cap = ovf_q[NSTEP] || qt_fin[DIST_W-1];
		neg_cap = ovf_q[NSTEP] || (qt_fin[DIST_W-1] && (|qt_fin[DIST_W-2:0]));
		if (neg_q[NSTEP]) begin
			dist_sat = neg_cap ? {1'b1, {(DIST_W-1){1'b0}}} : (~qt_fin + 1'b1);
		end else begin
			dist_sat = pos_cap ? {1'b0, {(DIST_W-1){1'b1}}} : qt_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= vld_q[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= hit_q[NSTEP];
			miss_reason <= reason_q[NSTEP];
			hit_distance <= hit_q[NSTEP] ? $signed(dist_sat) : '0;
			bary_u <= hit_q[NSTEP] ? qu_q[NSTEP] : '0;
			bary_v <= hit_q[NSTEP] ? qv_q[NSTEP] : '0;
		end
	end

endmodule

// ===== hdl/ray_triangle_intersection_core.sv =====
// top level of the ray-triangle intersection core: ray registers, credit control, wiring
//
// moller-trumbore ray/triangle test in exact fixed point. the ray (origin, unit
// direction, determinant threshold) sits in configuration registers written through
// cfg_wr_en/cfg_index/cfg_data; the user must write them only while the core is idle;
// the core itself does not enforce this. each tri_valid/tri_stall transaction brings
// one triangle and each res_valid/res_stall transaction returns one result in the same
// order. a triangle can be taken every clock cycle while tri_stall is low. the triangle
// passes 8 register stages in the front pipeline (edges, cross products, split dot
// products, sign fix, miss checks), the first loaded at the accepting edge, one in the
// queue and 34 in the back pipeline, where one quotient bit per stage of three restoring
// dividers gives 32 stages for the distance, plus the entry stage and the output
// register. the front pipeline never stops; tri_stall rises only when the triangles in
// the front pipeline plus those waiting in the queue reach QUEUE_DEPTH, so a stalled
// output backs up into the queue and then the input. with QUEUE_DEPTH of at least 10 a
// stall-free output sustains one triangle per cycle.
module ray_triangle_intersection_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,

	// configuration writes
	input logic cfg_wr_en,
	input logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rti_pkg::CFG_DATA_W-1:0] cfg_data,

	// triangle channel
	input logic tri_valid,
	output logic tri_stall,
	input logic signed [rti_pkg::COORD_W-1:0] v0_x,
	input logic signed [rti_pkg::COORD_W-1:0] v0_y,
	input logic signed [rti_pkg::COORD_W-1:0] v0_z,
	input logic signed [rti_pkg::COORD_W-1:0] v1_x,
	input logic signed [rti_pkg::COORD_W-1:0] v1_y,
	input logic signed [rti_pkg::COORD_W-1:0] v1_z,
	input logic signed [rti_pkg::COORD_W-1:0] v2_x,
	input logic signed [rti_pkg::COORD_W-1:0] v2_y,
	input logic signed [rti_pkg::COORD_W-1:0] v2_z,

	// result channel
	output logic res_valid,
	input logic res_stall,
	output logic hit,
	output logic [1:0] miss_reason,
	output logic signed [rti_pkg::DIST_W-1:0] hit_distance,
	output logic [rti_pkg::BARY_W-1:0] bary_u,
	output logic [rti_pkg::BARY_W-1:0] bary_v
);
	import rti_pkg::*;

	localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);

	rti_ray_t ray_q;
	rti_facet_t facet;
	logic tri_accept;
	logic item_valid;
	rti_item_t item;
	logic head_valid;
	rti_item_t head;
	logic pop;
	logic [CREDIT_W-1:0] credit_q;

	// ray registers, reset to origin zero looking down +x
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_q.org_x <= '0;
			ray_q.org_y <= '0;
			ray_q.org_z <= '0;
			ray_q.dir_x <= DIR_W'(65536);
			ray_q.dir_y <= '0;
			ray_q.dir_z <= '0;
			ray_q.det_eps <= EPS_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ORIGIN_X: ray_q.org_x <= cfg_data;
				REG_ORIGIN_Y: ray_q.org_y <= cfg_data;
				REG_ORIGIN_Z: ray_q.org_z <= cfg_data;
				REG_DIR_X: ray_q.dir_x <= cfg_data[DIR_W-1:0];
				REG_DIR_Y: ray_q.dir_y <= cfg_data[DIR_W-1:0];
				REG_DIR_Z: ray_q.dir_z <= cfg_data[DIR_W-1:0];
				REG_DET_EPS: ray_q.det_eps <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign facet.v0_x = v0_x;
	assign facet.v0_y = v0_y;
	assign facet.v0_z = v0_z;
	assign facet.v1_x = v1_x;
	assign facet.v1_y = v1_y;
	assign facet.v1_z = v1_z;
	assign facet.v2_x = v2_x;
	assign facet.v2_y = v2_y;
	assign facet.v2_z = v2_z;

	// credits cover the front pipeline and the queue, so the queue never overflows
	assign tri_stall = (credit_q == CREDIT_W'(QUEUE_DEPTH));
	assign tri_accept = tri_valid && !tri_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (tri_accept && !pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (pop && !tri_accept) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	rti_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(tri_accept),
		.facet(facet),
		.ray(ray_q),
		.item_valid(item_valid),
		.item(item)
	);

	rti_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(item_valid),
		.din(item),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	rti_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.hit(hit),
		.miss_reason(miss_reason),
		.hit_distance(hit_distance),
		.bary_u(bary_u),
		.bary_v(bary_v)
	);

endmodule
